// ===== rtl/mva_pkg.sv =====
package mva_pkg;

    localparam int NUM_VOICES  = 9;
    localparam int VOICE_IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    localparam int STATUS_W = 8;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int CHAN_W   = 4;
    localparam int CMD_W    = 4;
    localparam int VOICE_W  = 4;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 4'h8;
    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 4'h9;

    localparam logic ACT_KEY_ON  = 1'b0;
    localparam logic ACT_KEY_OFF = 1'b1;

    typedef struct packed {
        logic                   free_found;
        logic [VOICE_IDX_W-1:0] free_idx;
        logic                   match_found;
        logic [VOICE_IDX_W-1:0] match_idx;
    } t_pick;

endpackage

// ===== rtl/mva_voice_pick.sv =====
module mva_voice_pick (
    input  logic [mva_pkg::NUM_VOICES-1:0]                   i_busy,
    input  logic [mva_pkg::NUM_VOICES-1:0][mva_pkg::NOTE_W-1:0] i_notes,
    input  logic [mva_pkg::NUM_VOICES-1:0][mva_pkg::CHAN_W-1:0] i_chans,
    input  logic [mva_pkg::NOTE_W-1:0]                        i_note,
    input  logic [mva_pkg::CHAN_W-1:0]                        i_chan,
    output mva_pkg::t_pick                                    o_pick
);

    always_comb begin
        o_pick = '0;
        // scan from the top so the lowest hit wins
        for (int i = mva_pkg::NUM_VOICES - 1; i >= 0; i--) begin
            if (!i_busy[i]) begin
                o_pick.free_found = 1'b1;
                o_pick.free_idx   = mva_pkg::VOICE_IDX_W'(i);
            end
            if (i_busy[i] && (i_notes[i] == i_note) && (i_chans[i] == i_chan)) begin
                o_pick.match_found = 1'b1;
                o_pick.match_idx   = mva_pkg::VOICE_IDX_W'(i);
            end
        end
    end

endmodule

// ===== rtl/midi_voice_allocator.sv =====
// MIDI voice allocator.
// Slave channel: one word per three-byte MIDI message (status, note, velocity).
// Master channel: one word per key event; note-on always gives a key-on,
// note-off gives a key-off only when a busy voice holds that note and channel,
// every other status gives nothing.
// Note-on claims the lowest free voice, or overwrites voice 0 (stolen = 1)
// when all voices are busy.
// A message waits in the input register, and its event is then registered in the
// output register for the master side. Throughput: one message per cycle while
// the receiver does not stall, as the search of the voice table is combinational.
// When the receiver stalls, the output register holds its word and the input
// register keeps taking at most one more message, then tready drops.
// Synchronous reset clears every voice to free with note and channel zero,
// and empties both registers.
module midi_voice_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [7:0] status_byte, [14:8] note_number, [21:15] velocity
    input  logic [mva_pkg::S_DATA_W-1:0]  i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [3:0] voice, [10:4] note_out, [14:11] midi_channel, [15] stolen
    output logic [mva_pkg::M_DATA_W-1:0]  o_m_tdata,
    // [0] action
    output logic                          o_m_tuser
);

    logic                                                r_in_valid;
    logic [mva_pkg::STATUS_W-1:0]                        r_in_status;
    logic [mva_pkg::NOTE_W-1:0]                          r_in_note;

    logic [mva_pkg::NUM_VOICES-1:0]                      r_busy;
    logic [mva_pkg::NUM_VOICES-1:0][mva_pkg::NOTE_W-1:0] r_notes;
    logic [mva_pkg::NUM_VOICES-1:0][mva_pkg::CHAN_W-1:0] r_chans;

    logic                                                r_out_valid;
    logic                                                r_out_action;
    logic [mva_pkg::VOICE_W-1:0]                         r_out_voice;
    logic [mva_pkg::NOTE_W-1:0]                          r_out_note;
    logic [mva_pkg::CHAN_W-1:0]                          r_out_chan;
    logic                                                r_out_stolen;

    logic [mva_pkg::CMD_W-1:0]                           w_cmd;
    logic [mva_pkg::CHAN_W-1:0]                          w_chan;
    mva_pkg::t_pick                                      w_pick;
    logic                                                w_fire;
    logic                                                w_on;
    logic                                                w_off;
    logic [mva_pkg::VOICE_IDX_W-1:0]                     n_on_idx;

    assign w_cmd  = r_in_status[mva_pkg::STATUS_W-1 -: mva_pkg::CMD_W];
    assign w_chan = r_in_status[mva_pkg::CHAN_W-1:0];

    mva_voice_pick u_pick (
        .i_busy  (r_busy),
        .i_notes (r_notes),
        .i_chans (r_chans),
        .i_note  (r_in_note),
        .i_chan  (w_chan),
        .o_pick  (w_pick)
    );

    assign w_fire   = r_in_valid && (!r_out_valid || i_m_tready);
    assign w_on     = (w_cmd == mva_pkg::CMD_NOTE_ON);
    assign w_off    = (w_cmd == mva_pkg::CMD_NOTE_OFF) && w_pick.match_found;
    assign n_on_idx = w_pick.free_found ? w_pick.free_idx : '0;

    assign o_s_tready = !r_in_valid || w_fire;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_action;
    assign o_m_tdata  = {r_out_stolen, r_out_chan, r_out_note, r_out_voice};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_busy      <= '0;
            r_notes     <= '0;
            r_chans     <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_fire) begin
                r_out_valid <= w_on || w_off;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire && w_on) begin
                r_busy[n_on_idx]  <= 1'b1;
                r_notes[n_on_idx] <= r_in_note;
                r_chans[n_on_idx] <= w_chan;
            end
            if (w_fire && w_off) begin
                r_busy[w_pick.match_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_status <= i_s_tdata[mva_pkg::STATUS_W-1:0];
            r_in_note   <= i_s_tdata[mva_pkg::STATUS_W +: mva_pkg::NOTE_W];
        end
        if (w_fire) begin
            r_out_action <= w_on ? mva_pkg::ACT_KEY_ON : mva_pkg::ACT_KEY_OFF;
            r_out_voice  <= w_on ? mva_pkg::VOICE_W'(n_on_idx)
                                 : mva_pkg::VOICE_W'(w_pick.match_idx);
            r_out_note   <= r_in_note;
            r_out_chan   <= w_chan;
            r_out_stolen <= w_on && !w_pick.free_found;
        end
    end

`ifndef SYNTHESIS
    a_steal_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_on && !w_pick.free_found) |-> (&r_busy))
        else $error("voice stolen while a voice was free");

    a_stolen_is_voice0_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_stolen) |->
        (r_out_voice == '0 && r_out_action == mva_pkg::ACT_KEY_ON))
        else $error("stolen flag on a wrong event");

    a_on_marks_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_on) |=> r_busy[$past(n_on_idx)])
        else $error("keyed-on voice not busy");

    a_off_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_off) |=> !r_busy[$past(w_pick.match_idx)])
        else $error("keyed-off voice still busy");
`endif

endmodule
